FILE: rtl/core/quaternion_to_rotation_matrix_assert.svh
// ----------------------------------------------------------------------------
// Quaternion to rotation matrix - assertion macros
// Concurrent check macros; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_TO_ROTATION_MATRIX_ASSERT_SVH
`define QUATERNION_TO_ROTATION_MATRIX_ASSERT_SVH

`ifndef SYNTH

// same-cycle implication
`define QRM_AST_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("qrm check failed");

// implication with a fixed delay
`define QRM_AST_DLY(lbl, clk, rst_n, ante, dly, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
		else $error("qrm latency check failed");

`else

`define QRM_AST_IMP(lbl, clk, rst_n, ante, cons)
`define QRM_AST_DLY(lbl, clk, rst_n, ante, dly, cons)

`endif

`endif

FILE: rtl/core/qrm_pkg.sv
// ----------------------------------------------------------------------------
// Quaternion to rotation matrix - package
// Result width and matrix entry positions (row-major).
// ----------------------------------------------------------------------------
package qrm_pkg;

	localparam int OUT_W = 16;
	localparam int N_ENT = 9;

	localparam int E00 = 0;
	localparam int E01 = 1;
	localparam int E02 = 2;
	localparam int E10 = 3;
	localparam int E11 = 4;
	localparam int E12 = 5;
	localparam int E20 = 6;
	localparam int E21 = 7;
	localparam int E22 = 8;

endpackage

FILE: rtl/core/quaternion_to_rotation_matrix.sv
// ----------------------------------------------------------------------------
// Quaternion to rotation matrix
// Registers from start to done: capture, products, sums, norm, divider, output.
// Throughput: one quaternion per cycle; busy is always low, nothing stalls.
// The depth is set by the nine restoring dividers, one quotient bit per stage.
// Reset clears all valid bits; the payload pipeline is not reset.
// ----------------------------------------------------------------------------
`include "quaternion_to_rotation_matrix_assert.svh"

module quaternion_to_rotation_matrix
	import qrm_pkg::*;
#(
	parameter int IN_WIDTH = 16,
	parameter int OUT_FRAC = 14
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic signed [IN_WIDTH-1:0] q_w,
	input  logic signed [IN_WIDTH-1:0] q_x,
	input  logic signed [IN_WIDTH-1:0] q_y,
	input  logic signed [IN_WIDTH-1:0] q_z,
	output logic                       done,
	output logic signed [OUT_W-1:0]    r00,
	output logic signed [OUT_W-1:0]    r01,
	output logic signed [OUT_W-1:0]    r02,
	output logic signed [OUT_W-1:0]    r10,
	output logic signed [OUT_W-1:0]    r11,
	output logic signed [OUT_W-1:0]    r12,
	output logic signed [OUT_W-1:0]    r20,
	output logic signed [OUT_W-1:0]    r21,
	output logic signed [OUT_W-1:0]    r22,
	output logic                       zero_norm
);

	localparam int PW   = 2 * IN_WIDTH;      // product width
	localparam int SW   = PW + 1;            // pair sum width
	localparam int NW   = PW + 1;            // norm / magnitude width
	localparam int NUMW = PW + 2;            // signed numerator width
	localparam int TW   = NW + 1;            // partial remainder width
	localparam int QB   = OUT_FRAC + 2;      // quotient bits: integer + OUT_FRAC + round
	localparam int EW   = (QB + 1 > OUT_W) ? QB + 1 : OUT_W;
	localparam int LAT_P = QB + 6;           // sample distance start -> done
	localparam logic [QB-1:0] LIM = QB'(1) << OUT_FRAC;

	// stage 1: input capture
	logic                       vld_s1;
	logic signed [IN_WIDTH-1:0] qw_s1, qx_s1, qy_s1, qz_s1;

	// stage 2: products
	logic                 vld_s2;
	logic signed [PW-1:0] ww_s2, xx_s2, yy_s2, zz_s2;
	logic signed [PW-1:0] xy_s2, wz_s2, xz_s2, wy_s2, yz_s2, wx_s2;

	// stage 3: pair sums
	logic                 vld_s3;
	logic signed [SW-1:0] s_wx_s3, s_yz_s3, s_wy_s3, s_xz_s3, s_wz_s3, s_xy_s3;
	logic signed [SW-1:0] cr_s3 [6];

	// stage 4: norm and numerators
	logic                   vld_s4;
	logic [NW-1:0]          norm_s4;
	logic signed [NUMW-1:0] num_s4 [N_ENT];
	logic signed [NUMW-1:0] abs_c  [N_ENT];

	// divider pipeline, index 0 is loaded from stage 4
	logic          dv_vld_s  [QB+1];
	logic          dv_zero_s [QB+1];
	logic [NW-1:0] dv_norm_s [QB+1];
	logic [TW-1:0] dv_rem_s  [QB+1][N_ENT];
	logic [QB-1:0] dv_quo_s  [QB+1][N_ENT];
	logic          dv_neg_s  [QB+1][N_ENT];

	// output register
	logic                    done_q;
	logic                    zn_q;
	logic signed [OUT_W-1:0] res_q [N_ENT];
	logic signed [OUT_W-1:0] ent_c [N_ENT];
	logic                    over_c;
	logic                    rem_bad_c;

	assign busy = 1'b0;

	// ---------------------------------------------------------------- stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			dv_vld_s[0] <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			dv_vld_s[0] <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			qw_s1 <= q_w;
			qx_s1 <= q_x;
			qy_s1 <= q_y;
			qz_s1 <= q_z;
		end
	end

	// ---------------------------------------------------------------- stage 2
	always_ff @(posedge clk) begin
		ww_s2 <= qw_s1 * qw_s1;
		xx_s2 <= qx_s1 * qx_s1;
		yy_s2 <= qy_s1 * qy_s1;
		zz_s2 <= qz_s1 * qz_s1;
		xy_s2 <= qx_s1 * qy_s1;
		wz_s2 <= qw_s1 * qz_s1;
		xz_s2 <= qx_s1 * qz_s1;
		wy_s2 <= qw_s1 * qy_s1;
		yz_s2 <= qy_s1 * qz_s1;
		wx_s2 <= qw_s1 * qx_s1;
	end

	// ---------------------------------------------------------------- stage 3
	always_ff @(posedge clk) begin
		s_wx_s3 <= SW'(ww_s2) + SW'(xx_s2);
		s_yz_s3 <= SW'(yy_s2) + SW'(zz_s2);
		s_wy_s3 <= SW'(ww_s2) + SW'(yy_s2);
		s_xz_s3 <= SW'(xx_s2) + SW'(zz_s2);
		s_wz_s3 <= SW'(ww_s2) + SW'(zz_s2);
		s_xy_s3 <= SW'(xx_s2) + SW'(yy_s2);
		cr_s3[0] <= SW'(xy_s2) - SW'(wz_s2);
		cr_s3[1] <= SW'(xz_s2) + SW'(wy_s2);
		cr_s3[2] <= SW'(xy_s2) + SW'(wz_s2);
		cr_s3[3] <= SW'(yz_s2) - SW'(wx_s2);
		cr_s3[4] <= SW'(xz_s2) - SW'(wy_s2);
		cr_s3[5] <= SW'(yz_s2) + SW'(wx_s2);
	end

	// ---------------------------------------------------------------- stage 4
	always_ff @(posedge clk) begin
		norm_s4     <= unsigned'(s_wx_s3) + unsigned'(s_yz_s3);
		num_s4[E00] <= NUMW'(s_wx_s3) - NUMW'(s_yz_s3);
		num_s4[E11] <= NUMW'(s_wy_s3) - NUMW'(s_xz_s3);
		num_s4[E22] <= NUMW'(s_wz_s3) - NUMW'(s_xy_s3);
		num_s4[E01] <= {cr_s3[0], 1'b0};
		num_s4[E02] <= {cr_s3[1], 1'b0};
		num_s4[E10] <= {cr_s3[2], 1'b0};
		num_s4[E12] <= {cr_s3[3], 1'b0};
		num_s4[E20] <= {cr_s3[4], 1'b0};
		num_s4[E21] <= {cr_s3[5], 1'b0};
	end

	// sign / magnitude split, loads the divider
	always_comb begin
		for (int k = 0; k < N_ENT; k++) begin
			abs_c[k] = num_s4[k][NUMW-1] ? -num_s4[k] : num_s4[k];
		end
	end

	always_ff @(posedge clk) begin
		dv_zero_s[0] <= (norm_s4 == '0);
		dv_norm_s[0] <= norm_s4;
		for (int k = 0; k < N_ENT; k++) begin
			dv_rem_s[0][k] <= TW'(abs_c[k][NW-1:0]);
			dv_quo_s[0][k] <= '0;
			dv_neg_s[0][k] <= num_s4[k][NUMW-1];
		end
	end

	// ---------------------------------------------------------------- divider
	// Restoring division, one quotient bit per stage across all nine entries.
	for (genvar gi = 0; gi < QB; gi++) begin : g_step
		logic [N_ENT-1:0] ge;
		logic [NW-1:0]    diff [N_ENT];

		always_comb begin
			for (int k = 0; k < N_ENT; k++) begin
				ge[k] = dv_rem_s[gi][k] >= {1'b0, dv_norm_s[gi]};
				diff[k] = ge[k] ? NW'(dv_rem_s[gi][k] - {1'b0, dv_norm_s[gi]})
				                : dv_rem_s[gi][k][NW-1:0];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld_s[gi+1] <= 1'b0;
			end else begin
				dv_vld_s[gi+1] <= dv_vld_s[gi];
			end
		end

		always_ff @(posedge clk) begin
			dv_zero_s[gi+1] <= dv_zero_s[gi];
			dv_norm_s[gi+1] <= dv_norm_s[gi];
			for (int k = 0; k < N_ENT; k++) begin
				dv_rem_s[gi+1][k] <= {diff[k], 1'b0};
				dv_quo_s[gi+1][k] <= {dv_quo_s[gi][k][QB-2:0], ge[k]};
				dv_neg_s[gi+1][k] <= dv_neg_s[gi][k];
			end
		end
	end

	// ---------------------------------------------------------------- output
	// round half away from zero on the magnitude, clamp, then apply sign
	always_comb begin
		logic [QB:0]   rsum;
		logic [QB-1:0] rnd;
		logic [EW-1:0] ext;
		logic [EW-1:0] sval;
		over_c    = 1'b0;
		rem_bad_c = 1'b0;
		for (int k = 0; k < N_ENT; k++) begin
			rsum = {1'b0, dv_quo_s[QB][k]} + (QB+1)'(1);
			rnd  = rsum[QB:1];
			over_c = over_c | (rnd > LIM);
			rem_bad_c = rem_bad_c | (dv_rem_s[QB][k][TW-1:1] >= dv_norm_s[QB]);
			if (rnd > LIM) begin
				rnd = LIM;
			end
			ext  = EW'(rnd);
			sval = dv_neg_s[QB][k] ? (~ext + EW'(1)) : ext;
			ent_c[k] = dv_zero_s[QB] ? '0 : signed'(sval[OUT_W-1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			zn_q   <= 1'b0;
		end else begin
			done_q <= dv_vld_s[QB];
			zn_q   <= dv_vld_s[QB] && dv_zero_s[QB];
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < N_ENT; k++) begin
			res_q[k] <= ent_c[k];
		end
	end

	assign done      = done_q;
	assign zero_norm = zn_q;
	assign r00 = res_q[E00];
	assign r01 = res_q[E01];
	assign r02 = res_q[E02];
	assign r10 = res_q[E10];
	assign r11 = res_q[E11];
	assign r12 = res_q[E12];
	assign r20 = res_q[E20];
	assign r21 = res_q[E21];
	assign r22 = res_q[E22];

	// ---------------------------------------------------------------- checks
	`QRM_AST_IMP(a_zero_out, clk, arst_n, zero_norm,
		done && (r00 == '0) && (r01 == '0) && (r02 == '0) && (r10 == '0) && (r11 == '0)
		&& (r12 == '0) && (r20 == '0) && (r21 == '0) && (r22 == '0))
	`QRM_AST_IMP(a_done_src, clk, arst_n, done, $past(start, LAT_P))
	`QRM_AST_DLY(a_start_done, clk, arst_n, start && !busy, LAT_P, done)
	`QRM_AST_IMP(a_rem_bound, clk, arst_n, dv_vld_s[QB] && !dv_zero_s[QB], !rem_bad_c)
	`QRM_AST_IMP(a_mag_bound, clk, arst_n, dv_vld_s[QB] && !dv_zero_s[QB], !over_c)

endmodule

FILE: tb/sv/quaternion_to_rotation_matrix_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Quaternion to rotation matrix - testbench
// Drives quaternion beats through the start/busy handshake with random idle
// gaps, predicts each 3x3 matrix with exact integer division and rounding,
// and checks every done beat against the oldest pending prediction.
// ----------------------------------------------------------------------------
module quaternion_to_rotation_matrix_tb;
	import qrm_pkg::*;

	localparam int IN_W       = 16;
	localparam int FRAC       = 14;
	localparam int N_RANDOM   = 1650;
	localparam int TAIL_CYC   = 40;
	localparam int TIMEOUT_NS = 2_000_000;

	typedef struct packed {
		logic [N_ENT-1:0][OUT_W-1:0] ent;
		logic                        zn;
	} rot_mat_t;

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            start = 1'b0;
	logic            busy;
	logic [IN_W-1:0] q_w = '0;
	logic [IN_W-1:0] q_x = '0;
	logic [IN_W-1:0] q_y = '0;
	logic [IN_W-1:0] q_z = '0;
	logic            done;
	logic [OUT_W-1:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
	logic            zero_norm;

	rot_mat_t        rot_exp_q[$];
	int              err_cnt = 0;
	bit              idle_en = 1'b1;

	logic [IN_W-1:0] edge_vals [6] = '{16'h8000, 16'h7FFF, 16'h8001, 16'h0000, 16'h0001,
		16'hFFFF};

	quaternion_to_rotation_matrix #(
		.IN_WIDTH(IN_W),
		.OUT_FRAC(FRAC)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.q_w       (q_w),
		.q_x       (q_x),
		.q_y       (q_y),
		.q_z       (q_z),
		.done      (done),
		.r00       (r00),
		.r01       (r01),
		.r02       (r02),
		.r10       (r10),
		.r11       (r11),
		.r12       (r12),
		.r20       (r20),
		.r21       (r21),
		.r22       (r22),
		.zero_norm (zero_norm)
	);

	always #4 clk = ~clk;

	// exact rational entry scaled by 2^FRAC, ties away from zero, saturated
	function automatic rot_mat_t rot_from_quat(logic [IN_W-1:0] w, logic [IN_W-1:0] x,
		logic [IN_W-1:0] y, logic [IN_W-1:0] z);
		rot_mat_t res;
		longint   sw, sx, sy, sz, ww, xx, yy, zz, nrm, mag, quo;
		longint   num [N_ENT];
		sw  = longint'($signed(w));
		sx  = longint'($signed(x));
		sy  = longint'($signed(y));
		sz  = longint'($signed(z));
		ww  = sw * sw;
		xx  = sx * sx;
		yy  = sy * sy;
		zz  = sz * sz;
		nrm = ww + xx + yy + zz;
		res = '0;
		if (nrm == 0) begin
			res.zn = 1'b1;
			return res;
		end
		num[E00] = ww + xx - yy - zz;
		num[E01] = 2 * (sx * sy - sw * sz);
		num[E02] = 2 * (sx * sz + sw * sy);
		num[E10] = 2 * (sx * sy + sw * sz);
		num[E11] = ww - xx + yy - zz;
		num[E12] = 2 * (sy * sz - sw * sx);
		num[E20] = 2 * (sx * sz - sw * sy);
		num[E21] = 2 * (sy * sz + sw * sx);
		num[E22] = ww - xx - yy + zz;
		for (int k = 0; k < N_ENT; k++) begin
			mag = (num[k] < 0) ? -num[k] : num[k];
			quo = (mag <<< (FRAC + 1)) / nrm;
			quo = (quo + 1) >>> 1;
			if (quo > (longint'(1) <<< FRAC))
				quo = longint'(1) <<< FRAC;
			if (num[k] < 0)
				quo = -quo;
			res.ent[k] = quo[OUT_W-1:0];
		end
		return res;
	endfunction

	task automatic log_mismatch(string what, longint want, longint got);
		err_cnt++;
		if (err_cnt <= 10)
			$display("%t: %s expected %0d got %0d", $realtime, what, want, got);
	endtask

	// one quaternion beat; returns right after the edge that took it
	task automatic send_quat(logic [IN_W-1:0] w, logic [IN_W-1:0] x, logic [IN_W-1:0] y,
		logic [IN_W-1:0] z);
		int gap;
		if (idle_en && $urandom_range(99) < 34) begin
			gap = $urandom_range(1, 2);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		q_w   <= w;
		q_x   <= x;
		q_y   <= y;
		q_z   <= z;
		@(posedge clk);
		while (busy) @(posedge clk);
		rot_exp_q.push_back(rot_from_quat(w, x, y, z));
	endtask

	// hold off until every pending matrix has come back
	task automatic drain_pending();
		start <= 1'b0;
		@(posedge clk);
		while (rot_exp_q.size() != 0) @(posedge clk);
	endtask

	always @(posedge clk) begin : chk_result
		rot_mat_t got, want;
		if (arst_n && done) begin
			got.ent[E00] = r00;
			got.ent[E01] = r01;
			got.ent[E02] = r02;
			got.ent[E10] = r10;
			got.ent[E11] = r11;
			got.ent[E12] = r12;
			got.ent[E20] = r20;
			got.ent[E21] = r21;
			got.ent[E22] = r22;
			got.zn       = zero_norm;
			if (rot_exp_q.size() == 0) begin
				log_mismatch("unexpected done beat, zero_norm", -1, got.zn);
			end else begin
				want = rot_exp_q.pop_front();
				for (int k = 0; k < N_ENT; k++)
					if (got.ent[k] !== want.ent[k])
						log_mismatch($sformatf("r%0d%0d", k / 3, k % 3),
							$signed(want.ent[k]), $signed(got.ent[k]));
				if (got.zn !== want.zn)
					log_mismatch("zero_norm", want.zn, got.zn);
			end
		end
	end

	task automatic test_directed();
		send_quat(16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_quat(16'h0001, 16'h0000, 16'h0000, 16'h0000);
		send_quat(16'h7FFF, 16'h0000, 16'h0000, 16'h0000);
		send_quat(16'h8000, 16'h0000, 16'h0000, 16'h0000);
		send_quat(16'h0000, 16'h8000, 16'h0000, 16'h0000);
		send_quat(16'h0000, 16'h0000, 16'h8000, 16'h0000);
		send_quat(16'h0000, 16'h0000, 16'h0000, 16'h8000);
		send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
		send_quat(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
		send_quat(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
		send_quat(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
		send_quat(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_quat(16'h0001, 16'h0001, 16'h0001, 16'h0001);
		send_quat(16'h0000, 16'h0000, 16'h0000, 16'h0001);
		send_quat(16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_quat(16'h0001, 16'h0001, 16'h0000, 16'h0000);
		send_quat(16'h0000, 16'h0001, 16'h0001, 16'hFFFF);
		send_quat(16'h2D41, 16'h0000, 16'h2D41, 16'h0000);
		send_quat(16'h0003, 16'h0001, 16'h0001, 16'h0001);
		send_quat(16'h8000, 16'h0001, 16'h0000, 16'h0000);
		send_quat(16'h0001, 16'h8000, 16'h7FFF, 16'h0000);
		send_quat(16'h5555, 16'hAAAA, 16'h3333, 16'hCCCC);
		drain_pending();
	endtask

	task automatic test_random();
		int              sel, tmp;
		logic [IN_W-1:0] c [4];
		for (int i = 0; i < N_RANDOM; i++) begin
			// back-to-back beats for a long stretch in the middle
			idle_en = !(i >= 500 && i < 800);
			if (i == 900)
				drain_pending();
			sel = $urandom_range(99);
			for (int j = 0; j < 4; j++) begin
				if (sel < 55) begin
					c[j] = IN_W'($urandom);
				end else if (sel < 70) begin
					tmp  = int'($urandom_range(16)) - 8;
					c[j] = IN_W'(tmp);
				end else if (sel < 82) begin
					c[j] = $urandom_range(1) ? IN_W'($urandom) : '0;
				end else if (sel < 92) begin
					c[j] = edge_vals[$urandom_range(5)];
				end else if (sel < 96) begin
					c[j] = '0;
				end else begin
					// one dominant axis, small tilt on the rest
					tmp  = (j == 0) ? int'($urandom_range(32767)) : int'($urandom_range(64)) - 32;
					c[j] = IN_W'(tmp);
				end
			end
			send_quat(c[0], c[1], c[2], c[3]);
		end
		start <= 1'b0;
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_directed();
		test_random();
		while (rot_exp_q.size() != 0) @(posedge clk);
		repeat (TAIL_CYC) @(posedge clk);
		if (err_cnt == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
